FILE: hw/rtl/css_pkg.sv
// Package for the scheduling simulator: sizes, policy codes, register map, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package css_pkg;
  localparam int MaxProcsDef = 16;
  localparam int TimeW = 17;
  localparam int PidW = 8;
  localparam int ArrW = 16;
  localparam int BurstW = 12;

  localparam logic [1:0] MethodFcfs = 2'd0;
  localparam logic [1:0] MethodSjf  = 2'd1;
  localparam logic [1:0] MethodSrtf = 2'd2;

  localparam logic [1:0] AddrMethod = 2'd0;

  typedef enum logic [2:0] {
    StLoad, StScan, StRead, StRun, StFlush, StMetRead, StMetOut
  } state_t;
endpackage

FILE: hw/rtl/cpu_schedule_simulator.sv
// Scheduling simulator top level: load table, scan sequencer, result register.
// Depends on css_pkg.
// Loading takes one request per cycle while in_stall is low. The final request starts
// a run: each scheduling event is a scan of the N loaded processes, a read and a run;
// an idle jump is a scan alone. Then a flush, and a read and an output per metric.
// Output waits while out_stall is high. Reset (rst_n low) empties the table, selects FCFS.
`timescale 1ns / 1ps
module cpu_schedule_simulator #(
  parameter int MAX_PROCS = css_pkg::MaxProcsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_proc_id,
  input  logic [15:0] in_arrival_time,
  input  logic [11:0] in_burst_time,
  input  logic        in_last_process,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_kind,
  output logic [7:0]  out_proc_id,
  output logic [16:0] out_slice_start,
  output logic [16:0] out_slice_end,
  output logic [16:0] out_turnaround,
  output logic [16:0] out_waiting,
  output logic        out_last_record,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import css_pkg::*;
  localparam int IdxW = $clog2(MAX_PROCS);
  localparam int CntW = $clog2(MAX_PROCS + 1);
  localparam int EntW = PidW + ArrW + BurstW + BurstW + TimeW;

  logic [EntW-1:0] mem [MAX_PROCS];
  logic [EntW-1:0] rd_q;
  logic [IdxW-1:0] rd_a;
  logic            we;
  logic [IdxW-1:0] wa;
  logic [EntW-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_a];
  end

  logic [1:0] method_r;
  always_ff @(posedge clk) begin
    if (!rst_n) method_r <= MethodFcfs;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == AddrMethod)
      method_r <= cfg_pwdata[1:0];
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == AddrMethod) ? {30'd0, method_r} : 32'd0;

  state_t st_r, st_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt, ptr_r, ptr_nxt;
  logic [TimeW-1:0] t_r, t_nxt;
  logic sel_v_r, sel_v_nxt, any_r, any_nxt;
  logic [IdxW-1:0] sel_r, sel_nxt;
  logic [PidW-1:0] sel_pid_r, sel_pid_nxt;
  logic [ArrW-1:0] sel_arr_r, sel_arr_nxt, nxt_arr_r, nxt_arr_nxt;
  logic [BurstW-1:0] sel_key_r, sel_key_nxt;
  logic [TimeW-1:0] run_r, run_nxt;
  logic pv_r, pv_nxt;
  logic [PidW-1:0] pp_r, pp_nxt;
  logic [TimeW-1:0] ps_r, ps_nxt, pe_r, pe_nxt;
  logic [IdxW-1:0] rd_nxt_a;
  logic ov_r, ov_nxt, ok_r, ok_nxt, ol_r, ol_nxt;
  logic [PidW-1:0] op_r, op_nxt;
  logic [TimeW-1:0] os_r, os_nxt, oe_r, oe_nxt, ot_r, ot_nxt, ow_r, ow_nxt;

  logic [PidW-1:0]   e_pid;
  logic [ArrW-1:0]   e_arr;
  logic [BurstW-1:0] e_bur, e_rem, e_key;
  logic [TimeW-1:0]  e_cmp, ta, arr_gap;
  logic              better, rdy, live;

  assign {e_pid, e_arr, e_bur, e_rem, e_cmp} = rd_q;
  assign e_key = (method_r == MethodSjf) ? e_bur : e_rem;
  assign live  = e_rem != '0;
  assign rdy   = {1'b0, e_arr} <= t_r;
  assign arr_gap = {1'b0, e_arr} - t_r;
  assign ta    = (e_cmp > {1'b0, e_arr}) ? e_cmp - {1'b0, e_arr} : '0;

  always_comb begin
    better = 1'b0;
    if (method_r != MethodFcfs && e_key != sel_key_r) better = e_key < sel_key_r;
    else if (e_arr != sel_arr_r) better = e_arr < sel_arr_r;
    else better = e_pid < sel_pid_r;
  end

  assign in_stall = (st_r != StLoad) || ov_r;
  assign out_valid = ov_r;
  assign out_record_kind = ok_r;
  assign out_proc_id = op_r;
  assign out_slice_start = os_r;
  assign out_slice_end = oe_r;
  assign out_turnaround = ot_r;
  assign out_waiting = ow_r;
  assign out_last_record = ol_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; ptr_nxt = ptr_r; t_nxt = t_r;
    sel_v_nxt = sel_v_r; any_nxt = any_r; sel_nxt = sel_r;
    sel_pid_nxt = sel_pid_r; sel_arr_nxt = sel_arr_r; sel_key_nxt = sel_key_r;
    nxt_arr_nxt = nxt_arr_r; run_nxt = run_r;
    pv_nxt = pv_r; pp_nxt = pp_r; ps_nxt = ps_r; pe_nxt = pe_r;
    ov_nxt = ov_r && out_stall; ok_nxt = ok_r; ol_nxt = ol_r; op_nxt = op_r;
    os_nxt = os_r; oe_nxt = oe_r; ot_nxt = ot_r; ow_nxt = ow_r;
    we = 1'b0; wa = '0; wd = rd_q; rd_nxt_a = '0;
    unique case (st_r)
      StLoad: begin
        if (in_valid && !in_stall) begin
          if (cnt_r < CntW'(MAX_PROCS)) begin
            we = 1'b1; wa = cnt_r[IdxW-1:0];
            wd = {in_proc_id, in_arrival_time,
                  (in_burst_time == '0) ? BurstW'(1) : in_burst_time,
                  (in_burst_time == '0) ? BurstW'(1) : in_burst_time, TimeW'(0)};
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_last_process) begin
            st_nxt = StScan; t_nxt = '0; pv_nxt = 1'b0; ptr_nxt = '0;
            sel_v_nxt = 1'b0; any_nxt = 1'b0;
          end
        end
      end
      StScan: begin
        rd_nxt_a = ptr_r[IdxW-1:0];
        if (ptr_r != '0 && live) begin
          if (!any_r || e_arr < nxt_arr_r) nxt_arr_nxt = e_arr;
          any_nxt = 1'b1;
          if (rdy && (!sel_v_r || better)) begin
            sel_v_nxt = 1'b1; sel_nxt = ptr_r[IdxW-1:0] - 1'b1;
            sel_pid_nxt = e_pid; sel_arr_nxt = e_arr; sel_key_nxt = e_key;
          end
          if (!rdy && arr_gap < run_r) run_nxt = arr_gap;
        end
        if (ptr_r == '0) run_nxt = '1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == cnt_r) begin
          ptr_nxt = '0;
          if (!any_nxt) st_nxt = StFlush;
          else if (!sel_v_nxt) begin
            t_nxt = {1'b0, nxt_arr_nxt}; any_nxt = 1'b0;
          end else begin
            rd_nxt_a = sel_nxt; st_nxt = StRead;
          end
        end
      end
      StRead: begin
        rd_nxt_a = sel_r;
        st_nxt = StRun;
      end
      StRun: begin
        if (!ov_r || !out_stall) begin
          if (method_r < MethodSrtf || {5'd0, e_rem} < run_r) run_nxt = {5'd0, e_rem};
          else run_nxt = run_r;
          we = 1'b1; wa = sel_r;
          wd = {e_pid, e_arr, e_bur, e_rem - run_nxt[BurstW-1:0],
                (e_rem == run_nxt[BurstW-1:0]) ? t_r + run_nxt : e_cmp};
          if (pv_r && pp_r == e_pid && pe_r == t_r) pe_nxt = t_r + run_nxt;
          else begin
            if (pv_r) begin
              ov_nxt = 1'b1; ok_nxt = 1'b0; op_nxt = pp_r; os_nxt = ps_r;
              oe_nxt = pe_r; ot_nxt = '0; ow_nxt = '0; ol_nxt = 1'b0;
            end
            pv_nxt = 1'b1; pp_nxt = e_pid; ps_nxt = t_r; pe_nxt = t_r + run_nxt;
          end
          t_nxt = t_r + run_nxt;
          sel_v_nxt = 1'b0; any_nxt = 1'b0; st_nxt = StScan;
        end else rd_nxt_a = sel_r;
      end
      StFlush: begin
        if (!ov_r || !out_stall) begin
          if (pv_r) begin
            ov_nxt = 1'b1; ok_nxt = 1'b0; op_nxt = pp_r; os_nxt = ps_r;
            oe_nxt = pe_r; ot_nxt = '0; ow_nxt = '0; ol_nxt = (cnt_r == '0);
            pv_nxt = 1'b0;
          end
          ptr_nxt = '0; rd_nxt_a = '0;
          st_nxt = (cnt_r == '0) ? StLoad : StMetRead;
        end
      end
      StMetRead: begin
        rd_nxt_a = ptr_r[IdxW-1:0];
        st_nxt = StMetOut;
      end
      StMetOut: begin
        rd_nxt_a = ptr_r[IdxW-1:0];
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1; ok_nxt = 1'b1; op_nxt = e_pid; os_nxt = '0; oe_nxt = '0;
          ot_nxt = ta;
          ow_nxt = (ta > {5'd0, e_bur}) ? ta - {5'd0, e_bur} : '0;
          ol_nxt = (ptr_r + 1'b1 == cnt_r);
          ptr_nxt = ptr_r + 1'b1;
          rd_nxt_a = ptr_nxt[IdxW-1:0];
          if (ptr_r + 1'b1 == cnt_r) begin
            st_nxt = StLoad; cnt_nxt = '0; ptr_nxt = '0;
          end else st_nxt = StMetRead;
        end
      end
      default: st_nxt = StLoad;
    endcase
  end
  assign rd_a = rd_nxt_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StLoad; cnt_r <= '0; ptr_r <= '0; t_r <= '0; ov_r <= 1'b0;
      pv_r <= 1'b0; sel_v_r <= 1'b0; any_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ptr_r <= ptr_nxt; t_r <= t_nxt;
      ov_r <= ov_nxt; pv_r <= pv_nxt; sel_v_r <= sel_v_nxt; any_r <= any_nxt;
    end
    sel_r <= sel_nxt; sel_pid_r <= sel_pid_nxt; sel_arr_r <= sel_arr_nxt;
    sel_key_r <= sel_key_nxt; nxt_arr_r <= nxt_arr_nxt; run_r <= run_nxt;
    pp_r <= pp_nxt; ps_r <= ps_nxt; pe_r <= pe_nxt;
    ok_r <= ok_nxt; ol_r <= ol_nxt; op_r <= op_nxt; os_r <= os_nxt;
    oe_r <= oe_nxt; ot_r <= ot_nxt; ow_r <= ow_nxt;
  end
endmodule

FILE: test/cpu_schedule_simulator_tb.sv
// Testbench for cpu_schedule_simulator: loads process sets, checks Gantt slices and metrics
// against a scheduling predictor under every policy. Depends on css_pkg and the RTL top level.
`timescale 1ns / 1ps
module cpu_schedule_simulator_tb;
  import css_pkg::*;

  localparam int NProcs = 16;
  localparam logic [1:0] MethodAlt = 2'd3;
  localparam logic KindSlice = 1'b0;
  localparam logic KindMetric = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pid;
    logic [16:0] s;
    logic [16:0] e;
    logic [16:0] ta;
    logic [16:0] w;
    logic        last;
  } sched_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_proc_id = '0;
  logic [15:0] in_arrival_time = '0;
  logic [11:0] in_burst_time = '0;
  logic in_last_process = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_record_kind;
  logic [7:0] out_proc_id;
  logic [16:0] out_slice_start, out_slice_end, out_turnaround, out_waiting;
  logic out_last_record;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  cpu_schedule_simulator u_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  tbl_pid [NProcs];
  logic [15:0] tbl_arr [NProcs];
  logic [11:0] tbl_burst [NProcs];
  logic [11:0] tbl_rem [NProcs];
  logic [16:0] tbl_done [NProcs];
  int          tbl_count = 0;
  logic [1:0]  policy = MethodFcfs;
  sched_rec_t  expected_recs[$];
  int          errors = 0;
  bit          quiet_out = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic add_expected(input sched_rec_t r);
    expected_recs.insert(expected_recs.size(), r);
  endtask

  function automatic bit wins(int a, int b);
    logic [11:0] ka, kb;
    if (policy != MethodFcfs) begin
      ka = (policy == MethodSjf) ? tbl_burst[a] : tbl_rem[a];
      kb = (policy == MethodSjf) ? tbl_burst[b] : tbl_rem[b];
      if (ka != kb) return ka < kb;
    end
    if (tbl_arr[a] != tbl_arr[b]) return tbl_arr[a] < tbl_arr[b];
    if (tbl_pid[a] != tbl_pid[b]) return tbl_pid[a] < tbl_pid[b];
    return a < b;
  endfunction

  task automatic schedule_predict(input logic [7:0] pid, input logic [15:0] arr,
                                  input logic [11:0] burst, input logic last);
    int sel, n0;
    bit any, pv;
    logic [16:0] now, nxt, run, ps, pe, ta, w;
    logic [7:0] pp;
    sched_rec_t r;
    if (tbl_count < NProcs) begin
      tbl_pid[tbl_count] = pid;
      tbl_arr[tbl_count] = arr;
      tbl_burst[tbl_count] = (burst == 0) ? 12'd1 : burst;
      tbl_count++;
    end
    if (!last) return;
    n0 = expected_recs.size();
    for (int i = 0; i < tbl_count; i++) tbl_rem[i] = tbl_burst[i];
    now = 0; pv = 0; pp = 0; ps = 0; pe = 0;
    forever begin
      sel = -1; any = 0; nxt = 0;
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_rem[i] == 0) continue;
        if (!any || tbl_arr[i] < nxt) nxt = tbl_arr[i];
        any = 1;
        if (tbl_arr[i] <= now && (sel < 0 || wins(i, sel))) sel = i;
      end
      if (!any) break;
      if (sel < 0) begin
        now = nxt;
        continue;
      end
      run = tbl_rem[sel];
      if (policy >= MethodSrtf)
        for (int i = 0; i < tbl_count; i++)
          if (tbl_rem[i] != 0 && tbl_arr[i] > now && tbl_arr[i] - now < run)
            run = tbl_arr[i] - now;
      if (pv && pp == tbl_pid[sel] && pe == now) pe = now + run;
      else begin
        if (pv) add_expected('{KindSlice, pp, ps, pe, 0, 0, 1'b0});
        pv = 1; pp = tbl_pid[sel]; ps = now; pe = now + run;
      end
      now += run;
      tbl_rem[sel] -= run;
      if (tbl_rem[sel] == 0) tbl_done[sel] = now;
    end
    if (pv) add_expected('{KindSlice, pp, ps, pe, 0, 0, 1'b0});
    for (int i = 0; i < tbl_count; i++) begin
      ta = (tbl_done[i] > tbl_arr[i]) ? tbl_done[i] - tbl_arr[i] : 0;
      w = (ta > tbl_burst[i]) ? ta - tbl_burst[i] : 0;
      add_expected('{KindMetric, tbl_pid[i], 0, 0, ta, w, 1'b0});
    end
    if (expected_recs.size() > n0) begin
      r = expected_recs[$];
      r.last = 1'b1;
      expected_recs[$] = r;
    end
    tbl_count = 0;
  endtask

  function automatic int gap_len();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    return g;
  endfunction

  task automatic send_request(input logic [7:0] pid, input logic [15:0] arr,
                              input logic [11:0] burst, input logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_proc_id <= pid;
    in_arrival_time <= arr;
    in_burst_time <= burst;
    in_last_process <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_predict(pid, arr, burst, last);
  endtask

  task automatic set_policy(input logic [1:0] m);
    in_valid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= AddrMethod;
    cfg_pwdata <= {30'd0, m};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    policy = m;
  endtask

  // random set; small times mostly so runs stay short
  task automatic send_set(input int n, input bit wide);
    for (int i = 0; i < n; i++)
      send_request(8'($urandom_range(0, 255)),
                   wide ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 40)),
                   wide ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 12)),
                   i == n - 1);
  endtask

  always @(posedge clk) begin
    sched_rec_t x;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_recs.size() == 0)
        report_mismatch($sformatf("unexpected record pid %0d", out_proc_id));
      else begin
        x = expected_recs.pop_front();
        if (out_record_kind !== x.kind || out_proc_id !== x.pid ||
            out_slice_start !== x.s || out_slice_end !== x.e ||
            out_turnaround !== x.ta || out_waiting !== x.w ||
            out_last_record !== x.last)
          report_mismatch($sformatf(
            "got k%0d p%0d %0d-%0d ta%0d w%0d l%0d exp k%0d p%0d %0d-%0d ta%0d w%0d l%0d",
            out_record_kind, out_proc_id, out_slice_start, out_slice_end,
            out_turnaround, out_waiting, out_last_record, x.kind, x.pid, x.s, x.e,
            x.ta, x.w, x.last));
      end
    end
    if (quiet_out) out_stall <= 1'b0;
    else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 2) == 0) out_stall <= 1'b0;
  end

  task automatic test_directed();
    set_policy(MethodFcfs);
    send_request(8'd0, 16'd0, 12'd4095, 1'b1);
    send_request(8'd255, 16'd65535, 12'd1, 1'b0);
    send_request(8'd1, 16'd0, 12'd0, 1'b0);
    send_request(8'd255, 16'd5, 12'd3, 1'b1);
    set_policy(MethodSjf);
    send_request(8'd9, 16'd0, 12'd8, 1'b0);
    send_request(8'd3, 16'd1, 12'd2, 1'b0);
    send_request(8'd2, 16'd1, 12'd2, 1'b0);
    send_request(8'd7, 16'd100, 12'd5, 1'b1);
    set_policy(MethodSrtf);
    send_request(8'd4, 16'd0, 12'd10, 1'b0);
    send_request(8'd5, 16'd2, 12'd1, 1'b0);
    send_request(8'd4, 16'd3, 12'd1, 1'b1);
    set_policy(MethodAlt);
    send_request(8'd170, 16'd43690, 12'd2730, 1'b0);
    send_request(8'd85, 16'd21845, 12'd1365, 1'b1);
  endtask

  task automatic test_table_full();
    set_policy(MethodSrtf);
    for (int i = 0; i < 18; i++)
      send_request(i[7:0], 16'($urandom_range(0, 30)), 12'($urandom_range(1, 6)), i == 17);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 260) begin
      if ($urandom_range(0, 7) == 0) set_policy(2'($urandom_range(0, 3)));
      if ($urandom_range(0, 15) == 0) begin
        send_set(NProcs, 1'b1);
        sent += NProcs;
      end else begin
        int n;
        n = $urandom_range(1, 8);
        send_set(n, 1'b0);
        sent += n;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random();
    in_valid <= 1'b0;
    quiet_out = 1;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("cpu_schedule_simulator verification clean");
    else $display("cpu_schedule_simulator verification failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("cpu_schedule_simulator verification failed");
    $finish;
  end
endmodule
